>>> hw/rtl/ppc_pkg.sv
`timescale 1ns / 1ps

package ppc_pkg;

    // Default sizes; the top level takes them as parameters.
    localparam int TABLE_DEPTH_DEF       = 16;
    localparam int MAX_SECTION_BYTES_DEF = 1024;

    // Fixed field widths of the section syntax and of the result item.
    localparam int BYTE_W    = 8;
    localparam int PID_W     = 13;
    localparam int PID_HI_W  = PID_W - BYTE_W;
    localparam int VER_W     = 5;
    localparam int LEN_W     = 12;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int KIND_W    = 2;
    localparam int OUT_W     = PID_W + SLOT_W + VER_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Table id of a program association section.
    localparam logic [BYTE_W-1:0] TABLE_ID_PAT = 8'h00;

    // PIDs below this and at or above the null PID are rejected.
    localparam logic [PID_W-1:0] PID_MIN  = 13'h0010;
    localparam logic [PID_W-1:0] PID_NULL = 13'h1FFF;

    // Byte positions inside the section (table id is position zero).
    localparam int POS_LEN_HI    = 1;
    localparam int POS_LEN_LO    = 2;
    localparam int POS_VERSION   = 5;
    localparam int POS_FIRST_HI  = 10;
    // Header bytes after the length field that are not program entries (9),
    // expressed as the slack between an entry's last byte and the length.
    localparam int PID_TAIL_SLACK = 2;

    // Low byte phase of the position inside a four-byte program entry.
    localparam logic [1:0] PHASE_PID_HI = 2'd2;
    localparam logic [1:0] PHASE_PID_LO = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        EV_PID_ADDED     = 2'd0,
        EV_TABLE_CLEARED = 2'd1,
        EV_PID_INVALID   = 2'd2,
        EV_TABLE_FULL    = 2'd3
    } t_event_kind;

endpackage

>>> hw/rtl/ppc_pid_cell.sv
`timescale 1ns / 1ps

// One table slot. On a shift it takes the PID of its left neighbor, so the
// newest PID always sits in cell zero and the oldest one further right.
module ppc_pid_cell
    import ppc_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic [PID_W-1:0] i_pid_left,
    input  logic [CNT_W-1:0] i_count,
    input  logic [PID_W-1:0] i_key,
    output logic [PID_W-1:0] o_pid,
    output logic             o_match
);

    logic [PID_W-1:0] r_pid;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pid <= i_pid_left;
        end
    end

    // A cell holds a live PID only while its index is below the fill count.
    assign o_match = (CNT_W'(IDX) < i_count) && (r_pid == i_key);
    assign o_pid   = r_pid;

endmodule

>>> hw/rtl/ppc_out_skid.sv
`timescale 1ns / 1ps

// Output register with one skid entry behind it.
module ppc_out_skid #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_pop_ready
);

    logic         r_out_valid;
    logic [W-1:0] r_out;
    logic         r_skid_valid;
    logic [W-1:0] r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_pop_ready) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out       <= i_data;
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid       <= i_data;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

>>> hw/rtl/pat_section_pmt_pid_collector_unit.sv
`timescale 1ns / 1ps

// A result item is registered before it is offered. Throughput: one section
// byte per cycle while the output skid entry is empty; the PID table is a row
// of cells that all compare against the incoming PID in the same cycle.
// Reset (i_rst_n low at a clock edge): parser idle, no version held, table empty.
// Table slots themselves are not cleared; the fill count marks which are live.
module pat_section_pmt_pid_collector_unit
    import ppc_pkg::*;
#(
    parameter int TABLE_DEPTH       = TABLE_DEPTH_DEF,
    parameter int MAX_SECTION_BYTES = MAX_SECTION_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] section_byte
    input  logic [BYTE_W-1:0]      s_axis_tdata,
    // [0] section_start
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [12:0] pmt_pid, [16:13] slot_index, [21:17] table_version,
    // [26:22] entry_count, upper bits zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] event_kind
    output logic [KIND_W-1:0]      m_axis_tuser
);

    // Position counter covers every legal index; the incremented position
    // carries one more bit so that it can reach the section size limit.
    localparam int POS_W = $clog2(MAX_SECTION_BYTES);
    localparam int P_W   = POS_W + 1;
    localparam int CMP_W = (P_W + 1 > LEN_W) ? P_W + 1 : LEN_W;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SKID_W = KIND_W + OUT_W;

    // Parser state.
    logic [POS_W-1:0]    r_pos,        n_pos;
    logic                r_active,     n_active;
    logic [LEN_W-1:0]    r_len,        n_len;
    logic [VER_W-1:0]    r_version,    n_version;
    logic                r_ver_valid,  n_ver_valid;
    logic [PID_HI_W-1:0] r_pid_hi,     n_pid_hi;
    logic [CNT_W-1:0]    r_count,      n_count;

    logic                w_accept;
    logic [BYTE_W-1:0]   w_byte;
    logic                w_start;
    logic [P_W-1:0]      w_p;
    logic [PID_W-1:0]    w_key;
    logic [VER_W-1:0]    w_new_ver;
    logic                w_hit;
    logic                w_shift;
    logic                w_emit;
    t_event_kind         w_kind;
    logic [PID_W-1:0]    w_ev_pid;
    logic [SLOT_W-1:0]   w_ev_slot;
    logic [OUT_W-1:0]    w_ev_data;
    logic                w_skid_ready;
    logic [SKID_W-1:0]   w_skid_out;

    logic [TABLE_DEPTH-1:0] w_match;
    logic [PID_W-1:0]       w_cell_pid [TABLE_DEPTH];

    assign w_byte    = s_axis_tdata;
    assign w_start   = s_axis_tuser[0];
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_p       = {1'b0, r_pos} + P_W'(1);
    assign w_key     = {r_pid_hi, w_byte};
    assign w_new_ver = w_byte[VER_W:1];
    assign w_hit     = |w_match;

    // The row of table cells. A new PID enters cell zero and every live
    // entry moves one cell to the right, so cell k holds a live PID exactly
    // when k is below the fill count.
    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        logic [PID_W-1:0] w_left;
        if (k == 0) begin : g_head
            assign w_left = w_key;
        end else begin : g_body
            assign w_left = w_cell_pid[k-1];
        end
        ppc_pid_cell #(
            .IDX   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (w_shift),
            .i_pid_left (w_left),
            .i_count    (r_count),
            .i_key      (w_key),
            .o_pid      (w_cell_pid[k]),
            .o_match    (w_match[k])
        );
    end

    // Section walk. A start byte opens a section only for table id zero.
    // The length and version come from fixed header positions; from
    // position ten on, program entries repeat every four bytes with the PID
    // in the last two. Entries stop two bytes short of the section length,
    // which leaves the CRC out of the walk.
    always_comb begin
        n_pos       = r_pos;
        n_active    = r_active;
        n_len       = r_len;
        n_version   = r_version;
        n_ver_valid = r_ver_valid;
        n_pid_hi    = r_pid_hi;
        n_count     = r_count;
        w_shift     = 1'b0;
        w_emit      = 1'b0;
        w_kind      = EV_PID_ADDED;
        w_ev_pid    = '0;
        w_ev_slot   = '0;

        if (w_start) begin
            n_pos    = '0;
            n_len    = '0;
            n_active = (w_byte == TABLE_ID_PAT);
        end else if (r_active) begin
            if (w_p >= P_W'(MAX_SECTION_BYTES)) begin
                // Overlong section: stop and ignore the rest.
                n_active = 1'b0;
            end else begin
                n_pos = w_p[POS_W-1:0];
                if (w_p == P_W'(POS_LEN_HI)) begin
                    n_len = {w_byte[3:0], 8'h00};
                end else if (w_p == P_W'(POS_LEN_LO)) begin
                    n_len = {r_len[LEN_W-1:BYTE_W], w_byte};
                end else if (w_p == P_W'(POS_VERSION)) begin
                    if (!r_ver_valid || (w_new_ver != r_version)) begin
                        n_count     = '0;
                        n_version   = w_new_ver;
                        n_ver_valid = 1'b1;
                        w_emit      = 1'b1;
                        w_kind      = EV_TABLE_CLEARED;
                    end
                end else if (w_p >= P_W'(POS_FIRST_HI)) begin
                    if (w_p[1:0] == PHASE_PID_HI) begin
                        n_pid_hi = w_byte[PID_HI_W-1:0];
                    end else if ((w_p[1:0] == PHASE_PID_LO) &&
                                 ((CMP_W'(w_p) + CMP_W'(PID_TAIL_SLACK)) <=
                                  CMP_W'(r_len))) begin
                        w_ev_pid = w_key;
                        if ((w_key < PID_MIN) || (w_key >= PID_NULL)) begin
                            // Invalid PID ends the section.
                            n_active = 1'b0;
                            w_emit   = 1'b1;
                            w_kind   = EV_PID_INVALID;
                        end else if (!w_hit) begin
                            w_emit = 1'b1;
                            if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                w_kind = EV_TABLE_FULL;
                            end else begin
                                w_shift   = w_accept;
                                n_count   = r_count + CNT_W'(1);
                                w_kind    = EV_PID_ADDED;
                                w_ev_slot = SLOT_W'(r_count);
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_len       <= '0;
            r_version   <= '0;
            r_ver_valid <= 1'b0;
            r_pid_hi    <= '0;
            r_count     <= '0;
        end else if (w_accept) begin
            r_pos       <= n_pos;
            r_active    <= n_active;
            r_len       <= n_len;
            r_version   <= n_version;
            r_ver_valid <= n_ver_valid;
            r_pid_hi    <= n_pid_hi;
            r_count     <= n_count;
        end
    end

    // The result item carries the version and fill count after the event.
    assign w_ev_data = {COUNT_W'(n_count), n_version, w_ev_slot, w_ev_pid};

    // Results wait in a register with a skid entry behind it, so input
    // bytes keep flowing while the output side stalls until the skid entry fills.
    ppc_out_skid #(
        .W (SKID_W)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept && w_emit),
        .i_data      ({w_kind, w_ev_data}),
        .o_ready     (w_skid_ready),
        .o_valid     (m_axis_tvalid),
        .o_data      (w_skid_out),
        .i_pop_ready (m_axis_tready)
    );

    assign s_axis_tready = w_skid_ready;
    assign m_axis_tuser  = w_skid_out[SKID_W-1:OUT_W];
    assign m_axis_tdata  = OUT_TDATA_W'(w_skid_out[OUT_W-1:0]);

endmodule

>>> hw/rtl/ppc_port_checker.sv
`timescale 1ns / 1ps

module ppc_port_checker
    import ppc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]      m_axis_tuser
);

    logic [SLOT_W-1:0]  w_slot;
    logic [COUNT_W-1:0] w_count;
    logic [PID_W-1:0]   w_pid;

    assign w_pid   = m_axis_tdata[PID_W-1:0];
    assign w_slot  = m_axis_tdata[PID_W+SLOT_W-1:PID_W];
    assign w_count = m_axis_tdata[OUT_W-1:OUT_W-COUNT_W];

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // A new result only ever follows an accepted input byte.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result item without an input byte");

    // A clear empties the table and names no PID.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_TABLE_CLEARED) |->
            (w_count == '0) && (w_pid == '0) && (w_slot == '0))
        else $error("clear event with nonzero fields");

    // An added PID lands in the slot just below the new fill count.
    a_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_PID_ADDED) |->
            (w_slot == SLOT_W'(w_count - COUNT_W'(1))))
        else $error("added slot does not match the fill count");

    // A full event only occurs with the table at its depth.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_TABLE_FULL) |->
            (w_count == COUNT_W'(TABLE_DEPTH)) && (w_slot == '0))
        else $error("full event while the table has room");

endmodule

bind pat_section_pmt_pid_collector_unit ppc_port_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ppc_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
